FILE: rtl/core/mva_pkg.sv
// ---------------------------------------------------------------------------
// MIDI voice allocator package
// Shared widths, codes and the command and status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package mva_pkg;

   // Field widths fixed by the event and result formats.
   localparam int NOTE_W  = 7;
   localparam int CTRL_W  = 7;
   localparam int INDEX_W = 5;
   localparam int MASK_W  = 20;
   localparam int CSR_W   = 7;

   // Default voice count and reset values.
   localparam int VOICES_DEFAULT = 20;
   localparam logic [NOTE_W-1:0] NOTE_RESET      = 7'd64;
   localparam logic [CTRL_W-1:0] THRESHOLD_RESET = 7'd10;
   localparam logic [CTRL_W-1:0] CONTROLLER_RESET = 7'd64;

   // Event kinds carried by req_type.
   typedef enum logic [1:0] {
      EV_NOTE_ON  = 2'd0,
      EV_NOTE_OFF = 2'd1,
      EV_CONTROL  = 2'd2,
      EV_IGNORED  = 2'd3
   } event_kind_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_THRESHOLD  = 1'b0,
      CSR_CONTROLLER = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic search_step;
      logic scan_step;
      logic cc_apply;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;
      logic scan_last;
   } dp_status_type;

endpackage

FILE: rtl/core/mva_ctrl.sv
// ---------------------------------------------------------------------------
// MIDI voice allocator controller
// Sequences one item at a time: free-voice search, note table scan or
// pedal update, then a single result strobe.
// ---------------------------------------------------------------------------
module mva_ctrl
   import mva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_type,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_FLUSH  = 6'b001000,
      ST_CC     = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (event_kind_type'(req_type))
                  EV_NOTE_ON:  state_in = ST_SEARCH;
                  EV_NOTE_OFF: state_in = ST_SCAN;
                  EV_CONTROL:  state_in = ST_CC;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_done) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // The last table read is evaluated in this cycle.
            state_in = ST_RESP;
         end
         ST_CC: begin
            cmd.cc_apply = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule

FILE: rtl/core/mva_datapath.sv
// ---------------------------------------------------------------------------
// MIDI voice allocator datapath
// Voice note table, active and held flags, round-robin pointer, pedal
// state, configuration registers and the result registers.
// ---------------------------------------------------------------------------
module mva_datapath
   import mva_pkg::*;
#(
   parameter int VOICES = VOICES_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [NOTE_W-1:0]   req_note,
   input  logic [CTRL_W-1:0]   req_ctrl_number,
   input  logic [CTRL_W-1:0]   req_ctrl_value,
   input  logic                csr_wen,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,
   output logic                rsp_voice_started,
   output logic [INDEX_W-1:0]  rsp_voice_index,
   output logic [MASK_W-1:0]   rsp_released_mask,
   output logic                rsp_pedal_down
);

   localparam int IW = $clog2(VOICES);
   localparam logic [IW-1:0] LAST = IW'(VOICES - 1);

   // Note table: one write port, one registered read port.
   logic [NOTE_W-1:0] note_mem [VOICES];

   logic [VOICES-1:0] nvalid_ff, nvalid_in;
   logic [VOICES-1:0] active_ff, active_in;
   logic [VOICES-1:0] held_ff, held_in;
   logic [VOICES-1:0] rel_ff, rel_in;
   logic [IW-1:0]     next_ff, next_in;
   logic              pedal_ff, pedal_in;
   logic [CTRL_W-1:0] thr_ff, ctl_ff;

   logic [NOTE_W-1:0] note_ff;
   logic [CTRL_W-1:0] cnum_ff, cval_ff;
   logic [IW-1:0]     p_ff, p_in;
   logic [IW-1:0]     n_ff, n_in;
   logic [IW-1:0]     scan_ff, scan_in;
   logic              eval_vld_ff;
   logic [IW-1:0]     eval_idx_ff;
   logic [NOTE_W-1:0] note_q_ff;
   logic              valid_q_ff;
   logic              started_ff, started_in;
   logic [IW-1:0]     idx_ff, idx_in;

   logic              hit;
   logic [IW-1:0]     sel;
   logic              mem_we;
   logic [NOTE_W-1:0] eval_note;
   logic              pedal_new;

   function automatic logic [IW-1:0] inc_voice(input logic [IW-1:0] v);
      return (v == LAST) ? '0 : v + 1'b1;
   endfunction

   // Free-voice search: stop at an inactive voice, else steal the pointer.
   assign hit = !active_ff[p_ff];
   assign sel = hit ? p_ff : next_ff;
   assign status.search_done = hit || (n_ff == LAST);
   assign status.scan_last   = (scan_ff == LAST);
   assign mem_we = cmd.search_step && status.search_done;

   // An entry never written reads as the reset note.
   assign eval_note = valid_q_ff ? note_q_ff : NOTE_RESET;
   assign pedal_new = (cval_ff > thr_ff);

   // Voice flags, pointer and result updates.
   always_comb begin
      nvalid_in  = nvalid_ff;
      active_in  = active_ff;
      held_in    = held_ff;
      rel_in     = rel_ff;
      next_in    = next_ff;
      pedal_in   = pedal_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      scan_in    = scan_ff;
      started_in = started_ff;
      idx_in     = idx_ff;

      if (cmd.capture) begin
         rel_in     = '0;
         started_in = 1'b0;
         idx_in     = '0;
         p_in       = next_ff;
         n_in       = '0;
         scan_in    = '0;
      end

      if (cmd.search_step) begin
         if (status.search_done) begin
            nvalid_in[sel] = 1'b1;
            active_in[sel] = 1'b1;
            next_in        = inc_voice(sel);
            idx_in         = sel;
            started_in     = 1'b1;
         end else begin
            p_in = inc_voice(p_ff);
            n_in = n_ff + 1'b1;
         end
      end

      if (cmd.scan_step) begin
         scan_in = inc_voice(scan_ff);
      end

      // Note-off: act on the entry read in the previous cycle.
      if (eval_vld_ff && (eval_note == note_ff)) begin
         if (pedal_ff) begin
            held_in[eval_idx_ff] = 1'b1;
         end else begin
            if (active_ff[eval_idx_ff]) begin
               rel_in[eval_idx_ff] = 1'b1;
            end
            active_in[eval_idx_ff] = 1'b0;
         end
      end

      // Pedal controller: releasing the pedal frees every held voice at once.
      if (cmd.cc_apply && (cnum_ff == ctl_ff)) begin
         pedal_in = pedal_new;
         if (!pedal_new) begin
            rel_in    = active_ff & held_ff;
            active_in = active_ff & ~held_ff;
            held_in   = '0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff   <= '0;
         active_ff   <= '0;
         held_ff     <= '0;
         next_ff     <= '0;
         pedal_ff    <= 1'b0;
         eval_vld_ff <= 1'b0;
      end else begin
         nvalid_ff   <= nvalid_in;
         active_ff   <= active_in;
         held_ff     <= held_in;
         next_ff     <= next_in;
         pedal_ff    <= pedal_in;
         eval_vld_ff <= cmd.scan_step;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         ctl_ff <= CONTROLLER_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD:  thr_ff <= csr_wdata;
            CSR_CONTROLLER: ctl_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Item fields, counters and result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         note_ff <= req_note;
         cnum_ff <= req_ctrl_number;
         cval_ff <= req_ctrl_value;
      end
      p_ff        <= p_in;
      n_ff        <= n_in;
      scan_ff     <= scan_in;
      rel_ff      <= rel_in;
      started_ff  <= started_in;
      idx_ff      <= idx_in;
      eval_idx_ff <= scan_ff;
      valid_q_ff  <= nvalid_ff[scan_ff];
   end

   // Note table write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[sel] <= note_ff;
      end
      note_q_ff <= note_mem[scan_ff];
   end

   // Result formatting.
   logic [IW+INDEX_W-1:0] idx_ext;
   assign idx_ext = {{INDEX_W{1'b0}}, idx_ff};
   assign rsp_voice_index   = idx_ext[INDEX_W-1:0];
   assign rsp_voice_started = started_ff;
   assign rsp_pedal_down    = pedal_ff;

   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < VOICES) begin : g_live
         assign rsp_released_mask[j] = rel_ff[j];
      end else begin : g_zero
         assign rsp_released_mask[j] = 1'b0;
      end
   end

endmodule

FILE: rtl/core/midi_voice_allocator.sv
// From acceptance to the result strobe, a note-on searches for a free voice
// (one voice examined per cycle) and a note-off scans the note table (read
// one entry per cycle through its single read port). A new item can be taken
// in the cycle after the strobe. The receiver cannot stall. Synchronous reset
// restores the voice flags, pointer, pedal and configuration registers, and
// per-voice valid bits reset the note table; there is no clearing pass.
// ---------------------------------------------------------------------------
// MIDI voice allocator
// Round-robin polyphonic voice allocation with a sustain pedal; one result
// item for every event item.
// ---------------------------------------------------------------------------
module midi_voice_allocator
   import mva_pkg::*;
#(
   parameter int VOICES = VOICES_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [NOTE_W-1:0]  req_note,
   input  logic [CTRL_W-1:0]  req_ctrl_number,
   input  logic [CTRL_W-1:0]  req_ctrl_value,
   output logic               rsp_strobe,
   output logic               rsp_voice_started,
   output logic [INDEX_W-1:0] rsp_voice_index,
   output logic [MASK_W-1:0]  rsp_released_mask,
   output logic               rsp_pedal_down,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer.
   mva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Voice table and result registers.
   mva_datapath #(
      .VOICES (VOICES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_note          (req_note),
      .req_ctrl_number   (req_ctrl_number),
      .req_ctrl_value    (req_ctrl_value),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_voice_started (rsp_voice_started),
      .rsp_voice_index   (rsp_voice_index),
      .rsp_released_mask (rsp_released_mask),
      .rsp_pedal_down    (rsp_pedal_down)
   );

`ifndef ASSERT_OFF
   // An accepted item keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // A result is strobed only while an item is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe without an item in progress");

   // Each item gives a single strobe.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A note-on releases no voice; other events report voice index zero.
   a_started_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_voice_started ? (rsp_released_mask == '0)
                                        : (rsp_voice_index == '0)))
      else $error("inconsistent result fields");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// MIDI voice allocator testbench
// Drives note-on, note-off, control-change and ignored items into the
// allocator and predicts every result item from a model of its own. The
// model covers the voice table, the round-robin pointer and the sustain
// pedal. Each result is checked field by field, over several pedal threshold
// and controller settings and several rates of sender idling.
// ---------------------------------------------------------------------------
module testbench;
   import mva_pkg::*;

   localparam int NV             = VOICES_DEFAULT;
   localparam int QUIET_LIMIT    = 4000;
   localparam int PHASE_ITEMS    = 250;
   localparam int POOL_SIZE      = 16;

   // One event item as driven on the request ports.
   typedef struct packed {
      event_kind_type    kind;
      logic [NOTE_W-1:0] note;
      logic [CTRL_W-1:0] cnum;
      logic [CTRL_W-1:0] cval;
   } midi_event_type;

   // One result item as seen on the response ports.
   typedef struct packed {
      logic               started;
      logic [INDEX_W-1:0] index;
      logic [MASK_W-1:0]  released;
      logic               pedal;
   } voice_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = EV_IGNORED;
   logic [NOTE_W-1:0]  req_note = '0;
   logic [CTRL_W-1:0]  req_ctrl_number = '0;
   logic [CTRL_W-1:0]  req_ctrl_value = '0;
   logic               rsp_strobe;
   logic               rsp_voice_started;
   logic [INDEX_W-1:0] rsp_voice_index;
   logic [MASK_W-1:0]  rsp_released_mask;
   logic               rsp_pedal_down;
   logic               csr_wen = 1'b0;
   csr_index_type      csr_index = CSR_THRESHOLD;
   logic [CSR_W-1:0]   csr_wdata = '0;

   midi_event_type   note_events_q[$];
   voice_result_type expected_voice_q[$];

   // Predicted allocator state and its own copy of the registers.
   logic [NOTE_W-1:0] model_note [NV];
   logic              model_active [NV];
   logic              model_held [NV];
   int unsigned       model_ptr;
   logic              model_pedal;
   logic [CTRL_W-1:0] model_thr;
   logic [CTRL_W-1:0] model_ctl;

   // Settings known to the stimulus generator.
   int unsigned       gen_thr = 32'(THRESHOLD_RESET);
   int unsigned       gen_ctl = 32'(CONTROLLER_RESET);
   logic [NOTE_W-1:0] note_pool [POOL_SIZE];
   int unsigned       sender_idle_pct = 0;

   logic           taken = 1'b0;
   midi_event_type drive_ev;
   int             quiet_cycles = 0;
   int             fail_count = 0;
   int             n_items = 0;
   int             n_results = 0;
   int             n_steals = 0;
   int             n_pedal_releases = 0;
   int             n_csr_writes = 0;
   int             n_settings = 1;

   midi_voice_allocator #(.VOICES(NV)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_note          (req_note),
      .req_ctrl_number   (req_ctrl_number),
      .req_ctrl_value    (req_ctrl_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_voice_started (rsp_voice_started),
      .rsp_voice_index   (rsp_voice_index),
      .rsp_released_mask (rsp_released_mask),
      .rsp_pedal_down    (rsp_pedal_down),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Free-running clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Return the predicted voice table, pointer, pedal and registers to their state after reset.
   function automatic void reset_voice_table();
      for (int i = 0; i < NV; i++) begin
         model_note[i]   = NOTE_RESET;
         model_active[i] = 1'b0;
         model_held[i]   = 1'b0;
      end
      model_ptr   = 0;
      model_pedal = 1'b0;
      model_thr   = THRESHOLD_RESET;
      model_ctl   = CONTROLLER_RESET;
   endfunction

   // Apply one event item to the predicted state and return its result item.
   function automatic voice_result_type apply_midi_event(midi_event_type ev);
      voice_result_type r;
      int unsigned      p;
      int unsigned      n;
      r = '0;
      if (model_ptr >= NV) model_ptr = 0;
      case (ev.kind)
         EV_NOTE_ON: begin
            // Search from the pointer for a free voice; steal the pointer's
            // voice when every voice is sounding. The held mark is kept.
            p = model_ptr;
            n = 0;
            while (model_active[p] && n < NV) begin
               p = (p + 1) % NV;
               n++;
            end
            if (n == NV) n_steals++;
            model_note[p]   = ev.note;
            model_active[p] = 1'b1;
            r.started       = 1'b1;
            r.index         = INDEX_W'(p);
            model_ptr       = (p + 1) % NV;
         end
         EV_NOTE_OFF: begin
            // Every voice with this note is handled, sounding or not.
            for (int i = 0; i < NV; i++) begin
               if (model_note[i] == ev.note) begin
                  if (model_pedal) begin
                     model_held[i] = 1'b1;
                  end else begin
                     if (model_active[i] && i < MASK_W) r.released[i] = 1'b1;
                     model_active[i] = 1'b0;
                  end
               end
            end
         end
         EV_CONTROL: begin
            // Only the pedal controller matters; lifting the pedal lets go
            // of every held voice.
            if (ev.cnum == model_ctl) begin
               model_pedal = (ev.cval > model_thr);
               if (!model_pedal) begin
                  for (int i = 0; i < NV; i++) begin
                     if (model_held[i]) begin
                        if (model_active[i] && i < MASK_W) begin
                           r.released[i] = 1'b1;
                           n_pedal_releases++;
                        end
                        model_active[i] = 1'b0;
                        model_held[i]   = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.pedal = model_pedal;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Driver: presents the next pending item at the falling edge, holding it
   // until the block takes it.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (note_events_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
            drive_ev = note_events_q.pop_front();
            start           <= 1'b1;
            req_type        <= drive_ev.kind;
            req_note        <= drive_ev.note;
            req_ctrl_number <= drive_ev.cnum;
            req_ctrl_value  <= drive_ev.cval;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks result items, predicts accepted items, follows register
   // writes and watches for a stalled run.
   always @(posedge clock) begin
      midi_event_type   seen;
      voice_result_type want;
      if (reset) begin
         reset_voice_table();
         taken        <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_THRESHOLD:  model_thr = csr_wdata;
               CSR_CONTROLLER: model_ctl = csr_wdata;
               default: begin
               end
            endcase
         end

         if (rsp_strobe) begin
            n_results++;
            if (expected_voice_q.size() == 0) begin
               $error("result item with no item outstanding");
               fail_count++;
            end else begin
               want = expected_voice_q.pop_front();
               check_field("voice_started", 32'(want.started), 32'(rsp_voice_started));
               check_field("voice_index", 32'(want.index), 32'(rsp_voice_index));
               check_field("released_mask", 32'(want.released), 32'(rsp_released_mask));
               check_field("pedal_down", 32'(want.pedal), 32'(rsp_pedal_down));
            end
         end

         taken <= start && !busy;
         if (start && !busy) begin
            seen.kind = event_kind_type'(req_type);
            seen.note = req_note;
            seen.cnum = req_ctrl_number;
            seen.cval = req_ctrl_value;
            expected_voice_q.push_back(apply_midi_event(seen));
            n_items++;
         end

         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Timeout after %0d cycles with no item accepted", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic push_event(event_kind_type kind, logic [NOTE_W-1:0] note,
                             logic [CTRL_W-1:0] cnum, logic [CTRL_W-1:0] cval);
      midi_event_type ev;
      ev.kind = kind;
      ev.note = note;
      ev.cnum = cnum;
      ev.cval = cval;
      note_events_q.push_back(ev);
   endtask

   // Waits at rising edges until no item is pending, in flight or expected.
   task automatic wait_drained();
      while (note_events_q.size() != 0 || start || expected_voice_q.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      n_csr_writes++;
   endtask

   function automatic logic [NOTE_W-1:0] pick_note();
      return note_pool[$urandom_range(POOL_SIZE - 1, 0)];
   endfunction

   // Controller value that puts the pedal down or up under the current
   // threshold; with the threshold at its top the pedal can only be up.
   function automatic logic [CTRL_W-1:0] pedal_value(bit down);
      if (down && gen_thr < 127) return CTRL_W'($urandom_range(127, gen_thr + 1));
      if (down) return 7'd127;
      return CTRL_W'($urandom_range(gen_thr, 0));
   endfunction

   // Mostly playing on a small set of notes so that voices collide, fill up
   // and get stolen, with pedal moves, other controllers and ignored items
   // mixed in. Unused fields carry random values.
   task automatic queue_random_items(int count);
      int left;
      int roll;
      left = count;
      for (int i = 0; i < POOL_SIZE; i++) note_pool[i] = NOTE_W'($urandom);
      note_pool[0]             = '0;
      note_pool[POOL_SIZE - 1] = '1;
      while (left > 0) begin
         roll = $urandom_range(99, 0);
         if (roll < 2) begin
            // A chord wider than the voice table forces a steal.
            repeat (NV + 1) push_event(EV_NOTE_ON, pick_note(), CTRL_W'($urandom),
                                       CTRL_W'($urandom));
            left -= NV + 1;
         end else if (roll < 45) begin
            push_event(EV_NOTE_ON, pick_note(), CTRL_W'($urandom), CTRL_W'($urandom));
            left--;
         end else if (roll < 78) begin
            push_event(EV_NOTE_OFF, ($urandom_range(9, 0) == 0) ? NOTE_W'($urandom) : pick_note(),
                       CTRL_W'($urandom), CTRL_W'($urandom));
            left--;
         end else if (roll < 92) begin
            push_event(EV_CONTROL, NOTE_W'($urandom), CTRL_W'(gen_ctl),
                       pedal_value($urandom_range(1, 0) == 1));
            left--;
         end else if (roll < 97) begin
            push_event(EV_CONTROL, NOTE_W'($urandom), CTRL_W'($urandom), CTRL_W'($urandom));
            left--;
         end else begin
            push_event(EV_IGNORED, NOTE_W'($urandom), CTRL_W'($urandom), CTRL_W'($urandom));
            left--;
         end
      end
   endtask

   // Moves to new register settings once the block has gone quiet.
   task automatic change_settings(int unsigned thr, int unsigned ctl, int unsigned idle);
      wait_drained();
      write_csr(CSR_THRESHOLD, CSR_W'(thr));
      write_csr(CSR_CONTROLLER, CSR_W'(ctl));
      gen_thr = thr;
      gen_ctl = ctl;
      sender_idle_pct = idle;
      n_settings++;
      @(posedge clock);
   endtask

   // Stimulus: reset, directed items, then random phases over several
   // register settings and idle rates.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset settings.
      sender_idle_pct = 0;
      push_event(EV_IGNORED, 7'd0, 7'd0, 7'd0);
      push_event(EV_IGNORED, 7'd127, 7'd127, 7'd127);
      // Note-off on the untouched table matches every silent voice.
      push_event(EV_NOTE_OFF, NOTE_RESET, 7'd0, 7'd0);
      // Pedal just above the threshold, then pressed again.
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET, THRESHOLD_RESET + 7'd1);
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET, 7'd127);
      // With the pedal down, silent voices become held.
      push_event(EV_NOTE_OFF, NOTE_RESET, 7'd127, 7'd127);
      push_event(EV_NOTE_ON, 7'd0, 7'd0, 7'd0);
      push_event(EV_NOTE_ON, 7'd127, 7'd0, 7'd0);
      push_event(EV_NOTE_OFF, 7'd127, 7'd0, 7'd0);
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET - 7'd1, 7'd0);
      // Pedal exactly at the threshold counts as up and releases held voices.
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET, THRESHOLD_RESET);
      push_event(EV_NOTE_OFF, 7'd0, 7'd0, 7'd0);
      // The same note twice, then one note-off for both.
      push_event(EV_NOTE_ON, 7'd5, 7'd0, 7'd0);
      push_event(EV_NOTE_ON, 7'd5, 7'd0, 7'd0);
      push_event(EV_NOTE_OFF, 7'd5, 7'd0, 7'd0);
      push_event(EV_CONTROL, 7'd0, 7'd127, 7'd127);
      push_event(EV_CONTROL, 7'd0, 7'd0, 7'd0);
      // A held mark on a silent voice survives a new note-on there, so the
      // next pedal lift releases the new note.
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET, 7'd100);
      push_event(EV_NOTE_OFF, NOTE_RESET, 7'd0, 7'd0);
      push_event(EV_NOTE_ON, 7'd33, 7'd0, 7'd0);
      push_event(EV_CONTROL, 7'd0, CONTROLLER_RESET, 7'd0);
      push_event(EV_NOTE_ON, 7'd127, 7'd127, 7'd127);

      // Random phases.
      wait_drained();
      queue_random_items(PHASE_ITEMS);
      change_settings(0, 0, 81);
      queue_random_items(PHASE_ITEMS);
      change_settings(127, 127, 9);
      queue_random_items(PHASE_ITEMS);
      change_settings($urandom_range(126, 1), $urandom_range(127, 0), 0);
      queue_random_items(PHASE_ITEMS);
      change_settings(64, 64, 81);
      queue_random_items(PHASE_ITEMS);

      wait_drained();
      $display("Run covered %0d items and %0d results, with %0d voice steals",
               n_items, n_results, n_steals);
      $display("and %0d voices let go by the pedal; %0d register writes over %0d settings.",
               n_pedal_releases, n_csr_writes, n_settings);
      if (fail_count == 0 && expected_voice_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
